// File: hdl/kwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and fixed widths for the k-way merge min-select engine.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int VAL_W     = 32;
  localparam int CFG_W     = 4;
  localparam int RUN_IDX_W = 3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage : kwm_pkg
`default_nettype wire

// File: hdl/kwm_store_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_store_ram
// Single-port-write, single-port-read store with registered read data.
// ----------------------------------------------------------------------------
module kwm_store_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : kwm_store_ram
`default_nettype wire

// File: hdl/k_way_merge_min_select_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_merge_min_select_top
// Merge engine for sorted runs: load appends to a run, take pops the
// smallest head across the active runs (lowest run index wins on ties).
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A load writes the store in ST_LOAD and
// is passed on to the output register from ST_DONE; a take scans the active
// runs (active_runs capped at MAX_RUNS) in ST_SCAN, as the run heads are
// fetched from the single-read run store, compared one per cycle. The input is
// stalled while an item is in progress; a finished result may sit in the
// output register while the next beat is accepted. The store needs no
// clearing: only entries below a run's fill count are ever read.
// ----------------------------------------------------------------------------
module k_way_merge_min_select_top
  import kwm_pkg::*;
#(
  parameter int MAX_RUNS  = 8,
  parameter int RUN_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic        [CFG_W-1:0]     cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_operation,
  input  wire logic        [RUN_IDX_W-1:0] in_run_index,
  input  wire logic signed [VAL_W-1:0]     in_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed      [VAL_W-1:0]     out_merged_value,
  output logic                             out_found,
  output logic                             out_load_rejected
);

  localparam int RW    = $clog2(MAX_RUNS);
  localparam int CW    = RW + 1;
  localparam int PW    = $clog2(RUN_DEPTH + 1);
  localparam int MDEP  = MAX_RUNS * RUN_DEPTH;
  localparam int AW    = $clog2(MDEP);
  localparam logic [AW-1:0] DEPTH_A = AW'(RUN_DEPTH);
  localparam logic [PW-1:0] FULL_P  = PW'(RUN_DEPTH);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]     active_r;
  logic [CFG_W-1:0]     eff_n;

  op_t                  op_r, op_nxt;
  logic [RUN_IDX_W-1:0] run_r, run_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;

  logic [PW-1:0]        fill_r [MAX_RUNS];
  logic [PW-1:0]        rp_r   [MAX_RUNS];
  logic [RW-1:0]        cnt_idx;
  logic [PW-1:0]        sel_fill, sel_rp, sel_ptr;
  logic                 fill_we, rp_we;
  logic [PW-1:0]        fill_nxt, rp_nxt;

  logic [CW-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic                 p_v_r, p_v_nxt;
  logic [RW-1:0]        p_idx_r, p_idx_nxt;
  logic [PW-1:0]        p_rp_r, p_rp_nxt;

  logic                 have_r, have_nxt;
  logic [RW-1:0]        best_r, best_nxt;
  logic [VAL_W-1:0]     best_val_r, best_val_nxt;
  logic [PW-1:0]        best_rp_r, best_rp_nxt;

  logic [VAL_W-1:0]     res_val_r, res_val_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 res_rej_r, res_rej_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [VAL_W-1:0]     out_val_r;
  logic                 out_found_r, out_rej_r;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_addr;
  logic [VAL_W-1:0]     mem_q;
  logic                 load_rej;
  logic                 scan_more;

  always_comb begin
    eff_n = (32'(active_r) > MAX_RUNS) ? CFG_W'(MAX_RUNS) : active_r;
  end

  // one read port on the counter file, shared by load and scan
  always_comb begin
    cnt_idx  = (state_r == ST_LOAD) ? RW'(run_r) : scan_cnt_r[RW-1:0];
    sel_fill = fill_r[cnt_idx];
    sel_rp   = rp_r[cnt_idx];
    sel_ptr  = (state_r == ST_LOAD) ? sel_fill : sel_rp;
    mem_addr = AW'(cnt_idx) * DEPTH_A + AW'(sel_ptr);
    load_rej = (8'(run_r) >= 8'(eff_n)) || (sel_fill == FULL_P);
    scan_more = 8'(scan_cnt_r) < 8'(eff_n);
  end

  kwm_store_ram #(
    .DATA_W (VAL_W),
    .DEPTH  (MDEP)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_data (val_r),
    .rd_en   (mem_re),
    .rd_addr (mem_addr),
    .rd_data (mem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= CFG_W'(1);
      out_valid_r <= 1'b0;
      p_v_r       <= 1'b0;
      have_r      <= 1'b0;
      scan_cnt_r  <= '0;
      for (int i = 0; i < MAX_RUNS; i++) begin
        fill_r[i] <= '0;
        rp_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      p_v_r       <= p_v_nxt;
      have_r      <= have_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (fill_we) begin
        fill_r[cnt_idx] <= fill_nxt;
      end
      if (rp_we) begin
        rp_r[best_r] <= rp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    run_r       <= run_nxt;
    val_r       <= val_nxt;
    p_idx_r     <= p_idx_nxt;
    p_rp_r      <= p_rp_nxt;
    best_r      <= best_nxt;
    best_val_r  <= best_val_nxt;
    best_rp_r   <= best_rp_nxt;
    res_val_r   <= res_val_nxt;
    res_found_r <= res_found_nxt;
    res_rej_r   <= res_rej_nxt;
    if (out_load) begin
      out_val_r   <= res_val_r;
      out_found_r <= res_found_r;
      out_rej_r   <= res_rej_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    run_nxt       = run_r;
    val_nxt       = val_r;
    scan_cnt_nxt  = scan_cnt_r;
    p_v_nxt       = 1'b0;
    p_idx_nxt     = p_idx_r;
    p_rp_nxt      = p_rp_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    best_val_nxt  = best_val_r;
    best_rp_nxt   = best_rp_r;
    res_val_nxt   = res_val_r;
    res_found_nxt = res_found_r;
    res_rej_nxt   = res_rej_r;
    fill_we       = 1'b0;
    fill_nxt      = sel_fill + PW'(1);
    rp_we         = 1'b0;
    rp_nxt        = best_rp_r + PW'(1);
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt  = op_t'(in_operation);
          run_nxt = in_run_index;
          val_nxt = in_value;
          if (op_t'(in_operation) == OP_LOAD) begin
            state_nxt = ST_LOAD;
          end else begin
            scan_cnt_nxt = '0;
            have_nxt     = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end

      ST_LOAD: begin
        res_val_nxt   = '0;
        res_found_nxt = 1'b0;
        res_rej_nxt   = load_rej;
        if (!load_rej) begin
          mem_we  = 1'b1;
          fill_we = 1'b1;
        end
        state_nxt = ST_DONE;
      end

      ST_SCAN: begin
        // head fetched last cycle is compared against the running minimum
        if (p_v_r && (!have_r || ($signed(mem_q) < $signed(best_val_r)))) begin
          have_nxt     = 1'b1;
          best_nxt     = p_idx_r;
          best_val_nxt = mem_q;
          best_rp_nxt  = p_rp_r;
        end
        if (scan_more) begin
          scan_cnt_nxt = scan_cnt_r + CW'(1);
          p_idx_nxt    = scan_cnt_r[RW-1:0];
          p_rp_nxt     = sel_rp;
          if (sel_rp < sel_fill) begin
            mem_re  = 1'b1;
            p_v_nxt = 1'b1;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        res_found_nxt = have_r;
        res_rej_nxt   = 1'b0;
        res_val_nxt   = have_r ? best_val_r : '0;
        rp_we         = have_r;
        state_nxt     = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_merged_value  = out_val_r;
  assign out_found         = out_found_r;
  assign out_load_rejected = out_rej_r;

endmodule : k_way_merge_min_select_top
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-way merge min-select engine. A short table
// of load and take beats covers the field extremes, refused loads, exhausted
// runs, ties and active-run-count changes. Random phases over several
// active-run settings follow, with random idling on both channels. Every
// result beat is checked against a typed table result or the bench model.
// ----------------------------------------------------------------------------
module tb_top;
  import kwm_pkg::*;

  localparam int MAX_RUNS  = 8;
  localparam int RUN_DEPTH = 64;
  localparam int WD_LIMIT  = 5000;

  typedef struct packed {
    logic signed [VAL_W-1:0] merged;
    logic                    found;
    logic                    rejected;
  } merge_res_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    op_t            op;
    logic [2:0]     run;
    logic [31:0]    val;
    merge_res_t     res;
  } row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_operation = 1'b0;
  logic [RUN_IDX_W-1:0]    in_run_index = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_merged_value;
  logic                    out_found;
  logic                    out_load_rejected;

  // model of the engine
  logic signed [VAL_W-1:0] run_mem [MAX_RUNS][RUN_DEPTH];
  int                      fill_cnt [MAX_RUNS];
  int                      rd_ptr [MAX_RUNS];
  logic [CFG_W-1:0]        active_cfg = 4'd1;

  merge_res_t merge_exp_q [$];
  merge_res_t want_res;
  row_t       dir_rows [$];
  int unsigned phase_cfg [12] = '{8, 1, 9, 4, 0, 15, 2, 6, 8, 5, 3, 7};

  bit steady = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;
  int beats_in = 0, loads_ok = 0, loads_rej = 0, takes_hit = 0, takes_empty = 0;
  int cfg_writes = 0;

  k_way_merge_min_select_top #(
    .MAX_RUNS (MAX_RUNS),
    .RUN_DEPTH(RUN_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_run_index     (in_run_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_merged_value (out_merged_value),
    .out_found        (out_found),
    .out_load_rejected(out_load_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic merge_res_t merge_predict(op_t op, logic [2:0] run, logic [31:0] v);
    merge_res_t r;
    int n;
    int pick;
    logic signed [VAL_W-1:0] best;
    r = '0;
    n = (active_cfg > MAX_RUNS) ? MAX_RUNS : int'(active_cfg);
    pick = -1;
    best = '0;
    if (op == OP_LOAD) begin
      if (int'(run) >= n || fill_cnt[run] >= RUN_DEPTH) begin
        r.rejected = 1'b1;
      end else begin
        run_mem[run][fill_cnt[run]] = v;
        fill_cnt[run]++;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (rd_ptr[i] < fill_cnt[i] && (pick < 0 || run_mem[i][rd_ptr[i]] < best)) begin
          pick = i;
          best = run_mem[i][rd_ptr[i]];
        end
      end
      if (pick >= 0) begin
        rd_ptr[pick]++;
        r.merged = best;
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic row_t mk_row(row_kind_t k, op_t op, logic [2:0] run, logic [31:0] v,
                                  logic [31:0] xv, bit xf, bit xr);
    row_t r;
    r.kind = k;
    r.op = op;
    r.run = run;
    r.val = v;
    r.res.merged = xv;
    r.res.found = xf;
    r.res.rejected = xr;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  task automatic drive_item(input op_t op, input logic [2:0] run, input logic [31:0] v,
                            input bit typed, input merge_res_t typed_res);
    merge_res_t p;
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_run_index <= run;
    in_value     <= v;
    do @(posedge clk); while (in_stall);
    p = merge_predict(op, run, v);
    merge_exp_q.push_back(typed ? typed_res : p);
    beats_in++;
    if (op == OP_LOAD) begin
      if (p.rejected) loads_rej++; else loads_ok++;
    end else begin
      if (p.found) takes_hit++; else takes_empty++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (merge_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_active(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    active_cfg = v;
    cfg_writes++;
  endtask

  // result checking and output-side stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (merge_exp_q.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result beat: value %0d found %0b rejected %0b",
                   $realtime, out_merged_value, out_found, out_load_rejected);
        mismatches++;
      end else begin
        want_res = merge_exp_q.pop_front();
        if (out_merged_value !== want_res.merged || out_found !== want_res.found ||
            out_load_rejected !== want_res.rejected) begin
          if (mismatches < 10)
            $display("[%0t] mismatch (value/found/rejected): exp %0d/%0b/%0b got %0d/%0b/%0b",
                     $realtime, want_res.merged, want_res.found, want_res.rejected,
                     out_merged_value, out_found, out_load_rejected);
          mismatches++;
        end
      end
    end
    out_stall <= !steady && ($urandom_range(0, 99) < 36);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WD_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int          n_eff;
    int          len;
    op_t         op;
    logic [2:0]  run;
    logic [31:0] v;
    row_t        r;

    foreach (fill_cnt[i]) begin
      fill_cnt[i] = 0;
      rd_ptr[i] = 0;
    end

    // directed table
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd0, 32'h0, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_LOAD, 3'd1, 32'h0, 32'h0, 1'b0, 1'b1));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_LOAD, 3'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_LOAD, 3'd0, 32'h8000_0000, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd5, 32'h1234_5678, 32'h8000_0000, 1'b1, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd0, 32'h0, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, OP_LOAD, 3'd0, 32'd0, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_LOAD, 3'd0, 32'h1234_5678, 32'h0, 1'b0, 1'b1));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd0, 32'h0, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, OP_LOAD, 3'd0, 32'd15, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_LOAD, 3'd7, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_LOAD, 3'd3, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_LOAD, 3'd5, 32'h8000_0000, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, 3'd2, 32'd5, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd0, 32'h0, 32'h8000_0000, 1'b1, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd0, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, OP_TAKE, 3'd6, 32'h5555_5555, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, OP_LOAD, 3'd0, 32'd3, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_LOAD, 3'd6, 32'd7, 32'h0, 1'b0, 1'b1));
    dir_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, 3'd1, 32'd5, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, 3'd2, 32'd9, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, OP_TAKE, 3'd0, 32'hAAAA_AAAA, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, OP_LOAD, 3'd0, 32'd2, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd0, 32'h0, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, OP_LOAD, 3'd0, 32'd8, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, OP_TAKE, 3'd0, 32'h0, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, OP_TAKE, 3'd0, 32'h0, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_TAKE, 3'd0, 32'h0, 32'h0, 1'b0, 1'b0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) write_active(r.val[CFG_W-1:0]);
      else drive_item(r.op, r.run, r.val, r.kind == ROW_TYPED, r.res);
    end

    // random phases, one active-run setting each
    for (int ph = 0; ph < 12; ph++) begin
      write_active(phase_cfg[ph][CFG_W-1:0]);
      steady = (ph == 3);
      n_eff = (active_cfg > MAX_RUNS) ? MAX_RUNS : int'(active_cfg);
      len = (n_eff == 0) ? 40 : 150;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        op = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_TAKE;
        if (n_eff > 0 && $urandom_range(0, 99) < 85) run = 3'($urandom_range(0, n_eff - 1));
        else run = 3'($urandom_range(0, 7));
        v = pick_value();
        drive_item(op, run, v, 1'b0, '0);
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (16) @(posedge clk);

    $display("run summary: %0d beats, %0d active-run settings; loads stored %0d, refused %0d",
             beats_in, cfg_writes, loads_ok, loads_rej);
    $display("takes returning a value %0d, takes with every run exhausted %0d; mismatches %0d",
             takes_hit, takes_empty, mismatches);
    if (mismatches == 0 && merge_exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
